@@ hw/rtl/set_associative_cache_lru_core_defines.svh @@
// Assertion macros for the cache tag controller.
// Used by the top level; no other dependencies.
`ifndef SET_ASSOCIATIVE_CACHE_LRU_CORE_DEFINES_SVH
`define SET_ASSOCIATIVE_CACHE_LRU_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define SACL_ASSERT_IMPL(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define SACL_ASSERT_AT(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define SACL_ASSERT_IMPL(lbl, clk, rst_n, prop)
`define SACL_ASSERT_AT(lbl, clk, prop)
`endif
`endif

@@ hw/rtl/sacl_pkg.sv @@
// Shared types and constants of the cache tag controller.
// No dependencies.
`default_nettype none
package sacl_pkg;
    localparam int ADDR_WIDTH_DEF  = 32;
    localparam int MAX_SETS_DEF    = 64;
    localparam int MAX_WAYS_DEF    = 8;
    localparam int STAMP_WIDTH_DEF = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 4;
    localparam logic [CFG_IDX_W-1:0] REG_BOFF  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SBITS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WAYS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WA    = 3'd4;
    localparam logic [1:0] OP_NONE  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;
    localparam logic CMD_WRITE = 1'b0;
    typedef enum logic [1:0] {ST_IDLE, ST_LOOKUP, ST_EMIT} t_back_state;
endpackage
`default_nettype wire

@@ hw/rtl/sacl_front.sv @@
// Front end: accepts accesses into a two-entry queue.
// Depends on sacl_pkg.
`default_nettype none
module sacl_front #(
    parameter int ADDR_WIDTH = sacl_pkg::ADDR_WIDTH_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  wire                  i_cmd,
    input  wire [ADDR_WIDTH-1:0] i_addr,
    output logic                 o_valid,
    input  wire                  i_ready,
    output logic                 o_cmd,
    output logic [ADDR_WIDTH-1:0] o_addr
);
    import sacl_pkg::*;
    logic                  r_cmd [2];
    logic [ADDR_WIDTH-1:0] r_addr [2];
    logic                  r_wp, r_rp;
    logic [1:0]            r_cnt;
    logic                  w_push, w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_cmd[r_rp];
    assign o_addr  = r_addr[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_cmd[r_wp]  <= i_cmd;
            r_addr[r_wp] <= i_addr;
        end
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/sacl_back.sv @@
// Back end: set lookup, LRU victim choice, state update, result emission.
// Depends on sacl_pkg.
`default_nettype none
module sacl_back #(
    parameter int ADDR_WIDTH  = sacl_pkg::ADDR_WIDTH_DEF,
    parameter int MAX_SETS    = sacl_pkg::MAX_SETS_DEF,
    parameter int MAX_WAYS    = sacl_pkg::MAX_WAYS_DEF,
    parameter int STAMP_WIDTH = sacl_pkg::STAMP_WIDTH_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  wire                  i_cmd,
    input  wire [ADDR_WIDTH-1:0] i_addr,
    input  wire [3:0]            i_boff,
    input  wire [2:0]            i_sbits,
    input  wire [3:0]            i_ways,
    input  wire                  i_wt,
    input  wire                  i_wa,
    output logic                 o_valid,
    input  wire                  i_ready,
    output logic                 o_hit,
    output logic [1:0]           o_op,
    output logic [31:0]          o_laddr,
    output logic                 o_last
);
    import sacl_pkg::*;
    localparam int SMAX   = $clog2(MAX_SETS + 1) - 1;
    localparam int SET_W  = (SMAX > 0) ? SMAX : 1;
    localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int NSETS  = 1 << SMAX;
    localparam int LINE_W = 2 + ADDR_WIDTH + STAMP_WIDTH;

    // one memory row per set, all ways side by side
    logic [MAX_WAYS*LINE_W-1:0] r_mem [NSETS];
    logic [NSETS-1:0]           r_set_ok;     // row written since reset
    logic [MAX_WAYS*LINE_W-1:0] r_row;
    logic                       r_row_ok;
    t_back_state r_st, n_st;
    logic                  r_cmd;
    logic [ADDR_WIDTH-1:0] r_addr;
    logic [SET_W-1:0]      r_set;
    logic [STAMP_WIDTH-1:0] r_stamp;
    logic [1:0]  r_cnt;              // items left
    logic        r_hit2;
    logic [1:0]  r_op [2];
    logic [31:0] r_la [2];
    logic        r_sel;

    logic [3:0] w_boff, w_sb;
    logic [4:0] w_nways;
    logic [ADDR_WIDTH-1:0] w_tmask, w_tag;
    logic [SET_W-1:0] w_set_in;
    logic [ADDR_WIDTH-1:0] w_smask;

    always_comb begin
        w_boff = (i_boff > 4'd12) ? 4'd12 : i_boff;
        w_sb = ({1'b0, i_sbits} > 4'(SMAX)) ? 4'(SMAX) : {1'b0, i_sbits};
        w_nways = (i_ways == 4'd0) ? 5'd1 :
                  ({1'b0, i_ways} > 5'(MAX_WAYS)) ? 5'(MAX_WAYS) : {1'b0, i_ways};
        w_smask = ~({ADDR_WIDTH{1'b1}} << w_sb);
        w_tmask = {ADDR_WIDTH{1'b1}} << ({1'b0, w_boff} + {1'b0, w_sb});
    end
    assign w_set_in = SET_W'((i_addr >> w_boff) & w_smask);
    assign w_tag = r_addr & w_tmask;

    // way search over the registered row
    logic                   w_found;
    logic [WAY_W-1:0]       w_way, w_vic;
    logic                   w_vv, w_v, w_d;
    logic [ADDR_WIDTH-1:0]  w_t;
    logic [STAMP_WIDTH-1:0] w_vs, w_s;
    logic [MAX_WAYS*LINE_W-1:0] w_new_row;
    logic [LINE_W-1:0]      w_line;

    always_comb begin
        w_found = 1'b0;
        w_way = '0;
        w_vic = '0;
        w_vv = 1'b1;
        w_vs = '0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            w_line = r_row[w*LINE_W +: LINE_W];
            w_v = w_line[LINE_W-1] & r_row_ok;
            w_t = w_line[STAMP_WIDTH +: ADDR_WIDTH];
            w_s = r_row_ok ? w_line[STAMP_WIDTH-1:0] : '0;
            if (w < 32'(w_nways) && !w_found) begin
                if (w_v && w_t == w_tag) begin
                    w_found = 1'b1;
                    w_way = WAY_W'(w);
                end else if (w == 0 || (w_v != w_vv ? !w_v : w_s < w_vs)) begin
                    w_vic = WAY_W'(w);
                    w_vv = w_v;
                    w_vs = w_s;
                end
            end
        end
    end

    logic [WAY_W-1:0] w_sel_way;
    logic             w_alloc, w_wb;
    logic [LINE_W-1:0] w_old;
    assign w_sel_way = w_found ? w_way : w_vic;
    assign w_old = r_row[32'(w_sel_way)*LINE_W +: LINE_W];
    assign w_alloc = !w_found && (r_cmd != CMD_WRITE || i_wa);
    assign w_wb = w_alloc && r_row_ok && w_old[LINE_W-1] && w_old[LINE_W-2];

    always_comb begin
        w_new_row = r_row;
        if (!r_row_ok) w_new_row = '0;
        if (w_found) begin
            w_new_row[32'(w_sel_way)*LINE_W +: STAMP_WIDTH] = r_stamp;
            if (r_cmd == CMD_WRITE && !i_wt)
                w_new_row[32'(w_sel_way)*LINE_W + LINE_W-2] = 1'b1;
        end else if (w_alloc) begin
            w_new_row[32'(w_sel_way)*LINE_W +: LINE_W] =
                {1'b1, r_cmd == CMD_WRITE, w_tag, r_stamp};
        end
    end

    logic [ADDR_WIDTH-1:0] w_vaddr;
    assign w_vaddr = w_old[STAMP_WIDTH +: ADDR_WIDTH] |
                     (ADDR_WIDTH'(r_set) << w_boff);

    always_comb begin
        n_st = r_st;
        case (r_st)
            ST_IDLE:   if (i_valid) n_st = ST_LOOKUP;
            ST_LOOKUP: n_st = ST_EMIT;
            ST_EMIT:   if (i_ready && r_cnt == 2'd1) n_st = ST_IDLE;
            default:   n_st = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ready = (r_st == ST_IDLE);
        o_valid = (r_st == ST_EMIT);
        o_hit   = r_hit2;
        o_op    = r_op[r_sel];
        o_laddr = r_la[r_sel];
        o_last  = (r_cnt == 2'd1);
    end

    always_ff @(posedge i_clk) begin
        if (r_st == ST_IDLE && i_valid) begin
            r_row  <= r_mem[w_set_in];
            r_cmd  <= i_cmd;
            r_addr <= i_addr;
            r_set  <= w_set_in;
        end
        if (r_st == ST_LOOKUP) begin
            r_mem[r_set] <= w_new_row;
            r_hit2 <= w_found;
            r_op[0] <= w_wb ? OP_WRITE :
                       w_found ? ((r_cmd == CMD_WRITE && i_wt) ? OP_WRITE : OP_NONE) :
                       w_alloc ? OP_READ : OP_WRITE;
            r_la[0] <= w_wb ? 32'(w_vaddr) :
                       (w_found && !(r_cmd == CMD_WRITE && i_wt)) ? 32'd0 :
                       32'(r_addr);
            r_op[1] <= OP_READ;
            r_la[1] <= 32'(r_addr);
        end
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
            r_set_ok <= '0;
            r_row_ok <= 1'b0;
            r_stamp <= '0;
            r_cnt <= 2'd0;
            r_sel <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_st == ST_IDLE && i_valid) begin
                r_row_ok <= r_set_ok[w_set_in];
                r_stamp <= r_stamp + 1'b1;
            end
            if (r_st == ST_LOOKUP) begin
                r_set_ok[r_set] <= 1'b1;
                r_cnt <= w_wb ? 2'd2 : 2'd1;
                r_sel <= 1'b0;
            end else if (r_st == ST_EMIT && i_ready) begin
                r_cnt <= r_cnt - 2'd1;
                r_sel <= 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/set_associative_cache_lru_core.sv @@
// Top level of the cache tag controller: config registers, front queue, back end.
// Depends on sacl_pkg, sacl_front, sacl_back and the defines header.
// Usage:
//  s_axis: one access request per transfer; tdata = {address, command}
//    (command bit 0, address bits 32:1, zero pad to 40 bits).
//  m_axis: one or two result requests per access; tdata = {lower_address,
//    lower_op, hit} from bit 0, padded to 40 bits; tlast marks the final one.
//  Config: i_cfg_we/i_cfg_idx/i_cfg_data, write only while idle.
//  Pacing: the back end takes one access at a time, the next only after the
//  final result of the last is taken; the set row read (one memory port)
//  then the compare and row write-back set this. With the back end idle, a
//  queued access is read, looked up, then its first result is valid in ST_EMIT.
//  Input is taken into a two-entry queue until it is full, even while results
//  are stalled; a stalled m_axis holds its current request stable.
//  Reset: synchronous, clears control state, stamp and per-set valid bits;
//  lines of a set read as invalid until that set is first written, so no
//  clearing pass is needed.
`default_nettype none
`include "set_associative_cache_lru_core_defines.svh"
module set_associative_cache_lru_core #(
    parameter int ADDR_WIDTH  = sacl_pkg::ADDR_WIDTH_DEF,
    parameter int MAX_SETS    = sacl_pkg::MAX_SETS_DEF,
    parameter int MAX_WAYS    = sacl_pkg::MAX_WAYS_DEF,
    parameter int STAMP_WIDTH = sacl_pkg::STAMP_WIDTH_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire [39:0]  s_axis_tdata,   // command[0], address[32:1]
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [39:0] m_axis_tdata,   // hit[0], lower_op[2:1], lower_address[34:3]
    output logic        m_axis_tlast,
    input  wire         i_cfg_we,
    input  wire [sacl_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire [sacl_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import sacl_pkg::*;
    logic [3:0] r_boff, r_ways;
    logic [2:0] r_sbits;
    logic       r_wt, r_wa;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_boff <= 4'd6; r_sbits <= 3'd4; r_ways <= 4'd4; r_wt <= 1'b0; r_wa <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_BOFF:  r_boff  <= i_cfg_data;
                REG_SBITS: r_sbits <= i_cfg_data[2:0];
                REG_WAYS:  r_ways  <= i_cfg_data;
                REG_WT:    r_wt    <= i_cfg_data[0];
                REG_WA:    r_wa    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    logic                  w_q_valid, w_q_ready, w_q_cmd;
    logic [ADDR_WIDTH-1:0] w_q_addr, w_in_addr;
    logic                  w_hit;
    logic [1:0]            w_op;
    logic [31:0]           w_la;

    assign w_in_addr = ADDR_WIDTH'(s_axis_tdata[32:1]);

    sacl_front #(.ADDR_WIDTH(ADDR_WIDTH)) u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_cmd(s_axis_tdata[0]), .i_addr(w_in_addr),
        .o_valid(w_q_valid), .i_ready(w_q_ready), .o_cmd(w_q_cmd), .o_addr(w_q_addr)
    );

    sacl_back #(.ADDR_WIDTH(ADDR_WIDTH), .MAX_SETS(MAX_SETS), .MAX_WAYS(MAX_WAYS),
                .STAMP_WIDTH(STAMP_WIDTH)) u_back (
        .i_clk, .i_rst_n,
        .i_valid(w_q_valid), .o_ready(w_q_ready), .i_cmd(w_q_cmd), .i_addr(w_q_addr),
        .i_boff(r_boff), .i_sbits(r_sbits), .i_ways(r_ways), .i_wt(r_wt), .i_wa(r_wa),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_hit(w_hit), .o_op(w_op), .o_laddr(w_la), .o_last(m_axis_tlast)
    );

    assign m_axis_tdata = {5'd0, w_la, w_op, w_hit};

    // a hit never needs a lower-level read
    `SACL_ASSERT_IMPL(a_hit_no_fetch, i_clk, i_rst_n,
        (m_axis_tvalid && w_hit) |-> (w_op != OP_READ))
    // a non-final result is always a writeback
    `SACL_ASSERT_IMPL(a_wb_first, i_clk, i_rst_n,
        (m_axis_tvalid && !m_axis_tlast) |-> (w_op == OP_WRITE && !w_hit))
    `SACL_ASSERT_AT(a_rst_idle, i_clk, !i_rst_n |=> !m_axis_tvalid)
endmodule
`default_nettype wire
